// ----- rtl/core/mfcu_pkg.sv -----
package mfcu_pkg;

  localparam int unsigned ADDR_W     = 7;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CRC_W      = 8;
  localparam int unsigned FIELD_W    = 12;
  localparam int unsigned FRAME_BITS = 48;

  localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;
  localparam logic [CRC_W-1:0] REG_HIGH = 8'h28;
  localparam logic [CRC_W-1:0] REG_LOW  = 8'h29;

  // The first field sits in the lowest bits, so members are listed from the top down.
  typedef struct packed {
    logic [CRC_W-1:0]  low_crc;
    logic [WORD_W-1:0] low_word;
    logic [CRC_W-1:0]  high_crc;
    logic [WORD_W-1:0] high_word;
    logic [ADDR_W-1:0] device_address;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_z;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_x;
  } fields_t;

  // The CRC has no initial value and no final xor, so it is linear in the frame bits.
  // This returns the CRC of a frame in which only bit pos is set.
  function automatic logic [CRC_W-1:0] crc8_col(input int unsigned pos);
    logic [CRC_W-1:0] crc;
    logic             fb;
    crc = '0;
    for (int b = FRAME_BITS - 1; b >= 0; b--) begin
      fb  = crc[CRC_W-1] ^ (b == int'(pos));
      crc = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return crc;
  endfunction

endpackage

// ----- rtl/core/magnetometer_frame_check_unpack_top.sv -----
// Channel   Direction  tdata (low bit up)                                         tuser
// in_       slave      device_address, high_word, high_crc, low_word, low_crc, 0  none
// out_      master     field_x, field_y, field_z, 0 pad                           crc_ok
//
// One transfer is taken per cycle when the output side keeps up.
// Each transfer passes through two registers: the input register, then the result register.
// Both CRC checks and the unpacking sit between those two registers.
// A synchronous low rst_n empties both registers.
// While out_tready is low a valid result is held, and in_tready drops once both registers are full.
module magnetometer_frame_check_unpack_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // device_address[6:0], high_word[38:7], high_crc[46:39], low_word[78:47], low_crc[86:79]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // field_x[11:0], field_y[23:12], field_z[35:24], zero[39:36]
  output logic [39:0] out_tdata,
  // crc_ok[0]
  output logic [0:0]  out_tuser
);

  mfcu_pkg::in_item_t item_r, item_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  mfcu_pkg::fields_t  fields_r, fields_nxt;
  logic               crc_ok_r, crc_ok_nxt;
  logic               high_ok, low_ok;
  logic               out_load;

  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_load;

  mfcu_crc8_check #(.REG_NUM(mfcu_pkg::REG_HIGH)) u_crc_high (
    .device_address (item_r.device_address),
    .word           (item_r.high_word),
    .rx_crc         (item_r.high_crc),
    .match          (high_ok)
  );

  mfcu_crc8_check #(.REG_NUM(mfcu_pkg::REG_LOW)) u_crc_low (
    .device_address (item_r.device_address),
    .word           (item_r.low_word),
    .rx_crc         (item_r.low_crc),
    .match          (low_ok)
  );

  assign crc_ok_nxt = high_ok && low_ok;

  mfcu_unpack u_unpack (
    .high_word (item_r.high_word),
    .low_word  (item_r.low_word),
    .crc_ok    (crc_ok_nxt),
    .fields    (fields_nxt)
  );

  assign item_nxt      = in_tdata[$bits(mfcu_pkg::in_item_t)-1:0];
  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
    if (out_load && s1_valid_r) begin
      fields_r <= fields_nxt;
      crc_ok_r <= crc_ok_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {4'b0, fields_r};
  assign out_tuser[0] = crc_ok_r;

  a_bad_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[35:0] == 36'd0)
    else $error("fields not cleared on CRC mismatch");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_load |=> out_tvalid)
    else $error("input stage item lost");

  a_ok_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_load |=> out_tuser[0] == $past(high_ok && low_ok))
    else $error("crc_ok does not follow both checks");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s1_valid_r)
    else $error("pipeline not empty after reset");

endmodule

// ----- rtl/core/mfcu_crc8_check.sv -----
module mfcu_crc8_check #(
  parameter logic [7:0] REG_NUM = 8'h28
) (
  input  logic [mfcu_pkg::ADDR_W-1:0] device_address,
  input  logic [mfcu_pkg::WORD_W-1:0] word,
  input  logic [mfcu_pkg::CRC_W-1:0]  rx_crc,
  output logic                        match
);

  logic [mfcu_pkg::FRAME_BITS-1:0] frame;
  logic [mfcu_pkg::CRC_W-1:0]      terms [mfcu_pkg::FRAME_BITS];
  logic [mfcu_pkg::CRC_W-1:0]      crc;

  assign frame = {REG_NUM, device_address, 1'b1, word};

  for (genvar i = 0; i < int'(mfcu_pkg::FRAME_BITS); i++) begin : g_col
    localparam logic [mfcu_pkg::CRC_W-1:0] COL = mfcu_pkg::crc8_col(i);
    assign terms[i] = frame[i] ? COL : '0;
  end

  always_comb begin
    crc = '0;
    for (int i = 0; i < int'(mfcu_pkg::FRAME_BITS); i++) begin
      crc = crc ^ terms[i];
    end
  end

  assign match = (crc == rx_crc);

endmodule

// ----- rtl/core/mfcu_unpack.sv -----
module mfcu_unpack (
  input  logic [mfcu_pkg::WORD_W-1:0] high_word,
  input  logic [mfcu_pkg::WORD_W-1:0] low_word,
  input  logic                        crc_ok,
  output mfcu_pkg::fields_t           fields
);

  always_comb begin
    if (crc_ok) begin
      fields.field_x = {high_word[31:24], low_word[19:16]};
      fields.field_y = {high_word[23:16], low_word[15:12]};
      fields.field_z = {high_word[15:8],  low_word[11:8]};
    end else begin
      fields = '0;
    end
  end

endmodule

// ----- dv/mag_frame_crc_pkg.sv -----
`timescale 1ns / 1ps

package mag_frame_crc_pkg;

  // CRC-8 over register number, read address byte and the four data bytes, MSB first.
  function automatic logic [mfcu_pkg::CRC_W-1:0] frame_crc8(
      input logic [7:0]                   reg_num,
      input logic [mfcu_pkg::ADDR_W-1:0]  addr,
      input logic [mfcu_pkg::WORD_W-1:0]  word);
    logic [47:0]                frame;
    logic [mfcu_pkg::CRC_W-1:0] crc;
    frame = {reg_num, addr, 1'b1, word};
    crc   = '0;
    for (int i = 47; i >= 0; i--) begin
      crc = {crc[mfcu_pkg::CRC_W-2:0], 1'b0} ^
            ((crc[mfcu_pkg::CRC_W-1] ^ frame[i]) ? mfcu_pkg::CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

endpackage

// ----- dv/mag_frame_checker.sv -----
`timescale 1ns / 1ps

module mag_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [0:0]  out_tuser,
  output int          mismatches,
  output int          pending
);

  localparam int unsigned FIELD_W = mfcu_pkg::FIELD_W;

  typedef struct packed {
    mfcu_pkg::fields_t readings;
    logic              crc_ok;
  } frame_result_t;

  frame_result_t expected_readings[$];
  int            mismatch_count = 0;
  int            pending_count  = 0;

  assign mismatches = mismatch_count;
  assign pending    = pending_count;

  function automatic frame_result_t unpack_frame(input mfcu_pkg::in_item_t f);
    frame_result_t r;
    r = '0;
    r.crc_ok =
      (mag_frame_crc_pkg::frame_crc8(mfcu_pkg::REG_HIGH, f.device_address, f.high_word) ==
       f.high_crc) &&
      (mag_frame_crc_pkg::frame_crc8(mfcu_pkg::REG_LOW, f.device_address, f.low_word) ==
       f.low_crc);
    if (r.crc_ok) begin
      r.readings.field_x = {f.high_word[31:24], f.low_word[19:16]};
      r.readings.field_y = {f.high_word[23:16], f.low_word[15:12]};
      r.readings.field_z = {f.high_word[15:8], f.low_word[11:8]};
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [FIELD_W-1:0] exp_v,
                             input logic signed [FIELD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    frame_result_t     exp_r;
    mfcu_pkg::fields_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_readings.push_back(unpack_frame(mfcu_pkg::in_item_t'(in_tdata[86:0])));
      end
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $error("result transfer arrived with no frame outstanding");
          mismatch_count++;
        end else begin
          exp_r = expected_readings.pop_front();
          got   = out_tdata[35:0];
          check_field("field_x", exp_r.readings.field_x, got.field_x);
          check_field("field_y", exp_r.readings.field_y, got.field_y);
          check_field("field_z", exp_r.readings.field_z, got.field_z);
          check_field("crc_ok", FIELD_W'(exp_r.crc_ok), FIELD_W'(out_tuser[0]));
        end
      end
      pending_count = expected_readings.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_FRAMES = 1436;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_START    = 300;
  localparam int HOLD_CYCLES   = 120;
  localparam int QUIET_FIRST   = 600;
  localparam int QUIET_LAST    = 900;
  localparam int DRAIN_AT      = 1000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;

  int mismatches;
  int pending;
  int frames_sent = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  bit hold_done   = 0;

  mfcu_pkg::in_item_t frame;

  magnetometer_frame_check_unpack_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  mag_frame_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit quiet_stretch();
    return frames_sent >= QUIET_FIRST && frames_sent < QUIET_LAST;
  endfunction

  function automatic mfcu_pkg::in_item_t make_frame(
      input logic [mfcu_pkg::ADDR_W-1:0] addr,
      input logic [mfcu_pkg::WORD_W-1:0] hw,
      input logic [mfcu_pkg::WORD_W-1:0] lw);
    mfcu_pkg::in_item_t f;
    f.device_address = addr;
    f.high_word      = hw;
    f.low_word       = lw;
    f.high_crc       = mag_frame_crc_pkg::frame_crc8(mfcu_pkg::REG_HIGH, addr, hw);
    f.low_crc        = mag_frame_crc_pkg::frame_crc8(mfcu_pkg::REG_LOW, addr, lw);
    return f;
  endfunction

  // Bytes lean toward the sign and range boundaries of the readings.
  function automatic logic [mfcu_pkg::WORD_W-1:0] rand_word();
    logic [mfcu_pkg::WORD_W-1:0] w;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(7))
        0: w[8*i +: 8] = 8'h00;
        1: w[8*i +: 8] = 8'hFF;
        2: w[8*i +: 8] = 8'h80;
        3: w[8*i +: 8] = 8'h7F;
        default: w[8*i +: 8] = 8'($urandom_range(255));
      endcase
    end
    return w;
  endfunction

  task automatic send_frame(input mfcu_pkg::in_item_t f);
    while (!quiet_stretch() && $urandom_range(99) < 31) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, f};
    do @(posedge clk); while (!in_tready);
    frames_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  // The long hold-off lets the pipeline fill so that in_tready drops.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && frames_sent >= HOLD_START) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (quiet_stretch()) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_frame(make_frame(7'd0, 32'h0000_0000, 32'h0000_0000));
    send_frame(make_frame(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_frame(make_frame(7'd42, 32'h8080_80A5, 32'hC3F0_005A));
    send_frame(make_frame(7'd85, 32'h7F7F_7F00, 32'hFF0F_FF00));
    send_frame(make_frame(7'd1, 32'h0000_00FF, 32'hFF00_00FF));
    send_frame(make_frame(7'h55, 32'hAAAA_AAAA, 32'h5555_5555));
    send_frame(make_frame(7'h2A, 32'h5555_5555, 32'hAAAA_AAAA));

    frame = make_frame(7'd19, 32'h1234_5678, 32'h9ABC_DEF0);
    frame.high_crc ^= 8'h01;
    send_frame(frame);
    frame = make_frame(7'd100, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    frame.low_crc ^= 8'h80;
    send_frame(frame);
    frame = make_frame(7'd64, 32'h0102_0304, 32'h0506_0708);
    frame.high_crc = ~frame.high_crc;
    frame.low_crc  = ~frame.low_crc;
    send_frame(frame);
    frame = make_frame(7'd5, 32'h4433_2211, 32'h8877_6655);
    frame.device_address = 7'd6;
    send_frame(frame);
    frame = make_frame(7'd33, 32'hF00F_0FF0, 32'h0FF0_F00F);
    frame.high_word[0] = ~frame.high_word[0];
    send_frame(frame);
    frame = make_frame(7'd90, 32'h7FFF_8000, 32'h8000_7FFF);
    frame.low_word[31] = ~frame.low_word[31];
    send_frame(frame);
    frame = make_frame(7'd0, 32'h0000_0000, 32'h0000_0000);
    frame.high_crc = 8'h00;
    frame.low_crc  = 8'hFF;
    send_frame(frame);

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (frames_sent == DRAIN_AT) begin
        wait_all_results();
      end
      frame = make_frame(7'($urandom_range(127)), rand_word(), rand_word());
      if ($urandom_range(99) >= 80) begin
        case ($urandom_range(4))
          0: frame.high_crc ^= 8'(1 << $urandom_range(7));
          1: frame.low_crc ^= 8'(1 << $urandom_range(7));
          2: frame.high_word ^= 32'(1) << $urandom_range(31);
          3: frame.low_word ^= 32'(1) << $urandom_range(31);
          default: begin
            frame.high_crc = 8'($urandom_range(255));
            frame.low_crc  = 8'($urandom_range(255));
          end
        endcase
      end
      send_frame(frame);
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mfcu_pkg.sv
rtl/core/mfcu_crc8_check.sv
rtl/core/mfcu_unpack.sv
rtl/core/magnetometer_frame_check_unpack_top.sv
dv/mag_frame_crc_pkg.sv
dv/mag_frame_checker.sv
dv/tb.sv
